// ===== sv/mng_pkg.sv =====
`default_nettype none
package mng_pkg;

  // Pixel and result data width
  localparam int PIX_W = 8;

  // Configuration register widths
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;

  // Raster index of the next result
  localparam int IDX_W = 32;

  // Defaults
  localparam int DEF_MAX_LINE = 2048;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Depth of the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

  // Input mode codes
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // One queued operation for the window and gradient stage
  typedef struct packed {
    logic             shift;     // advance the window by one column
    logic             result;    // emit a result after this operation
    logic             border;    // result position lies on the frame border
    logic             frame_end; // last result of the frame
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] px;
  } q_entry_t;

endpackage
`default_nettype wire

// ===== sv/mng_if.sv =====
`default_nettype none
interface mng_in_if
  import mng_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output mode, output pixel, input ready);
  modport sink   (input valid, input mode, input pixel, output ready);
endinterface

interface mng_out_if
  import mng_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] grad_value;
  logic             frame_end;

  modport source (output valid, output grad_value, output frame_end, input ready);
  modport sink   (input valid, input grad_value, input frame_end, output ready);
endinterface
`default_nettype wire

// ===== sv/mng_front.sv =====
`default_nettype none
module mng_front
  import mng_pkg::*;
#(
  parameter int MAX_LINE = DEF_MAX_LINE
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  in_mode_i,
  input  wire logic [PIX_W-1:0]      in_pixel_i,
  output logic                       q_push_o,
  output q_entry_t                   q_entry_o,
  input  wire logic                  q_full_i
);

  localparam int CW    = $clog2(MAX_LINE);
  localparam int LW    = CW + 1;
  localparam int CMPW  = (LW > CFG_WIDTH_W) ? LW : CFG_WIDTH_W;
  localparam int TW    = LW + CFG_HEIGHT_W;
  localparam int CNT_W = $clog2(IDX_W);
  localparam int RST_W = (WIDTH_RESET > MAX_LINE) ? MAX_LINE : WIDTH_RESET;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } front_state_e;

  front_state_e state_q, state_d;

  logic [CFG_WIDTH_W-1:0]  fw_q;
  logic [CFG_HEIGHT_W-1:0] fh_q;
  logic [CMPW-1:0]         fw_ext;
  logic [LW-1:0]           w_eff;
  logic [CFG_HEIGHT_W-1:0] h_eff;
  logic [TW-1:0]           total_m1_q;

  logic [CW-1:0]           in_col_q, in_col_d;
  logic [CFG_HEIGHT_W-1:0] in_row_q, in_row_d;
  logic [IDX_W-1:0]        out_idx_q, out_idx_d;
  logic [IDX_W-1:0]        out_row_q, out_row_d;
  logic [CW-1:0]           out_col_q, out_col_d;

  logic [IDX_W-1:0]        dvd_q, dvd_d;
  logic [LW-1:0]           rem_q, rem_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [LW:0]             rem_shift;
  logic [LW:0]             rem_sub;
  logic                    qbit;
  logic [LW-1:0]           rem_new;

  logic                    f2_valid_q, f2_valid_d;
  logic                    f2_shift_q, f2_result_q, f2_border_q, f2_fe_q;
  logic [PIX_W-1:0]        f2_px_q;
  logic [CW-1:0]           f2_col_q;
  logic [2*PIX_W-1:0]      rd_q;
  logic [2*PIX_W-1:0]      line_mem [MAX_LINE];
  logic                    mem_we;

  logic                    f2_free;
  logic                    accept;
  logic                    in_row_full;
  logic                    is_pixel;
  logic                    is_drain;
  logic                    has_prev;
  logic                    emit;
  logic                    last;
  logic                    border;
  logic [LW-1:0]           col_inc;
  logic [LW-1:0]           ocol_inc;

  // Effective frame size: clamp width to 3..MAX_LINE, height to at least 3
  always_comb begin
    fw_ext = CMPW'(fw_q);
    priority if (fw_ext < CMPW'(3)) begin
      w_eff = LW'(3);
    end else if (fw_ext > CMPW'(MAX_LINE)) begin
      w_eff = LW'(MAX_LINE);
    end else begin
      w_eff = LW'(fw_ext);
    end
    h_eff = (fh_q < CFG_HEIGHT_W'(3)) ? CFG_HEIGHT_W'(3) : fh_q;
  end

  // Classify the offered transaction
  assign in_row_full = in_row_q >= h_eff;
  assign q_push_o    = f2_valid_q && !q_full_i;
  assign f2_free     = !f2_valid_q || q_push_o;
  assign in_ready_o  = (state_q == ST_RUN) && f2_free;
  assign accept      = in_valid_i && in_ready_o;
  assign is_pixel    = accept && (in_mode_i == MODE_PIXEL) && !in_row_full;
  assign is_drain    = accept && (in_mode_i == MODE_FLUSH) && in_row_full;
  assign has_prev    = (in_row_q >= CFG_HEIGHT_W'(2))
                    || ((in_row_q == CFG_HEIGHT_W'(1)) && (in_col_q != '0))
                    || ((in_row_q == '0) && (LW'(in_col_q) > w_eff));
  assign emit        = (is_pixel && has_prev) || is_drain;
  assign last        = out_idx_q >= IDX_W'(total_m1_q);
  assign border      = (out_row_q == '0)
                    || (out_row_q >= (IDX_W'(h_eff) - IDX_W'(1)))
                    || (out_col_q == '0)
                    || (LW'(out_col_q) >= (w_eff - LW'(1)));
  assign col_inc     = LW'(in_col_q) + LW'(1);
  assign ocol_inc    = LW'(out_col_q) + LW'(1);

  // Restoring divider step: output position = index / width
  assign rem_shift = {rem_q, dvd_q[IDX_W-1]};
  assign rem_sub   = rem_shift - {1'b0, w_eff};
  assign qbit      = rem_shift >= {1'b0, w_eff};
  assign rem_new   = qbit ? rem_sub[LW-1:0] : rem_shift[LW-1:0];

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_idx_d = out_idx_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    state_d   = state_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;

    if (is_pixel) begin
      if (col_inc >= w_eff) begin
        in_col_d = '0;
        in_row_d = in_row_q + CFG_HEIGHT_W'(1);
      end else begin
        in_col_d = col_inc[CW-1:0];
      end
    end

    if (emit) begin
      if (is_drain && last) begin
        // Frame drained: restart all positions
        in_col_d  = '0;
        in_row_d  = '0;
        out_idx_d = '0;
        out_row_d = '0;
        out_col_d = '0;
      end else begin
        out_idx_d = out_idx_q + IDX_W'(1);
        if (ocol_inc >= w_eff) begin
          out_col_d = '0;
          out_row_d = out_row_q + IDX_W'(1);
        end else begin
          out_col_d = ocol_inc[CW-1:0];
        end
      end
    end

    unique case (state_q)
      ST_RUN: begin
      end
      ST_DIV: begin
        dvd_d = {dvd_q[IDX_W-2:0], qbit};
        rem_d = rem_new;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(IDX_W - 1)) begin
          state_d   = ST_RUN;
          out_row_d = {dvd_q[IDX_W-2:0], qbit};
          out_col_d = rem_new[CW-1:0];
        end
      end
      default: state_d = ST_RUN;
    endcase

    // A new frame size re-derives the output position
    if (cfg_we_i) begin
      state_d = ST_DIV;
      dvd_d   = out_idx_q;
      rem_d   = '0;
      cnt_d   = '0;
    end
  end

  always_comb begin
    f2_valid_d = f2_valid_q;
    if (f2_free) begin
      f2_valid_d = is_pixel || is_drain;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      fw_q       <= CFG_WIDTH_W'(WIDTH_RESET);
      fh_q       <= CFG_HEIGHT_W'(HEIGHT_RESET);
      total_m1_q <= TW'(RST_W * HEIGHT_RESET - 1);
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_idx_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      f2_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      total_m1_q <= TW'(w_eff) * TW'(h_eff) - TW'(1);
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      out_idx_q  <= out_idx_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      f2_valid_q <= f2_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_FRAME_WIDTH:  fw_q <= cfg_wdata_i[CFG_WIDTH_W-1:0];
          REG_FRAME_HEIGHT: fh_q <= cfg_wdata_i[CFG_HEIGHT_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    if (f2_free) begin
      f2_shift_q  <= is_pixel;
      f2_result_q <= emit;
      f2_border_q <= border;
      f2_fe_q     <= last;
      f2_px_q     <= in_pixel_i;
      f2_col_q    <= in_col_q;
    end
  end

  // Line store: each entry holds {upper, middle}; written back when the entry is pushed to the queue
  assign mem_we = q_push_o && f2_shift_q;

  always_ff @(posedge clk_i) begin
    if (is_pixel) begin
      rd_q <= line_mem[in_col_q];
    end
    if (mem_we) begin
      line_mem[f2_col_q] <= {rd_q[PIX_W-1:0], f2_px_q};
    end
  end

  always_comb begin
    q_entry_o.shift     = f2_shift_q;
    q_entry_o.result    = f2_result_q;
    q_entry_o.border    = f2_border_q;
    q_entry_o.frame_end = f2_fe_q;
    q_entry_o.up        = rd_q[2*PIX_W-1:PIX_W];
    q_entry_o.mid       = rd_q[PIX_W-1:0];
    q_entry_o.px        = f2_px_q;
  end

`ifndef SYNTHESIS
  a_cfg_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("input taken while output position is re-derived");

  a_mem_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && is_pixel) |-> (f2_col_q != in_col_q))
    else $error("line store read and write back at one column");

  a_out_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (LW'(out_col_q) < w_eff))
    else $error("output column beyond frame width");

  a_drain_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_drain && last) |=> ((out_idx_q == '0) && (in_row_q == '0) && (in_col_q == '0)))
    else $error("positions not cleared after last drain");
`endif

endmodule
`default_nettype wire

// ===== sv/mng_queue.sv =====
`default_nettype none
module mng_queue
  import mng_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  q_entry_t      entry_i,
  output logic          full_o,
  output logic          valid_o,
  output q_entry_t      entry_o,
  input  wire logic     pop_i
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  q_entry_t      slots_q [QUEUE_DEPTH];
  logic [AW:0]   wr_ptr_q, rd_ptr_q;

  assign valid_o = wr_ptr_q != rd_ptr_q;
  assign full_o  = (wr_ptr_q[AW] != rd_ptr_q[AW]) && (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
  assign entry_o = slots_q[rd_ptr_q[AW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + (AW+1)'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q[AW-1:0]] <= entry_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mng_back.sv =====
`default_nettype none
module mng_back
  import mng_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  q_entry_t         q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [PIX_W-1:0] grad_o,
  output logic             frame_end_o
);

  logic [PIX_W-1:0] win_q [3][3];
  logic             mv_q;
  logic             m_border_q, m_fe_q;
  logic             ov_q;
  logic [PIX_W-1:0] grad_q;
  logic             fe_q;

  logic             out_load;
  logic             meta_free;
  logic [PIX_W-1:0] nb_max;
  logic [PIX_W-1:0] centre;
  logic [PIX_W-1:0] grad_val;

  assign out_load  = mv_q && (!ov_q || out_ready_i);
  assign meta_free = !mv_q || out_load;
  assign q_pop_o   = q_valid_i && meta_free;

  // Largest of the eight neighbours and its distance to the centre; zero on the border
  always_comb begin
    nb_max = '0;
    centre = win_q[1][1];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1) && (win_q[i][j] > nb_max)) begin
          nb_max = win_q[i][j];
        end
      end
    end
    if (m_border_q) begin
      grad_val = '0;
    end else if (nb_max >= centre) begin
      grad_val = nb_max - centre;
    end else begin
      grad_val = centre - nb_max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
      mv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (q_pop_o && q_entry_i.shift) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[0][2] <= q_entry_i.up;
        win_q[1][2] <= q_entry_i.mid;
        win_q[2][2] <= q_entry_i.px;
      end
      if (meta_free) begin
        mv_q <= q_pop_o && q_entry_i.result;
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (meta_free) begin
      m_border_q <= q_entry_i.border;
      m_fe_q     <= q_entry_i.frame_end;
    end
    if (out_load) begin
      grad_q <= grad_val;
      fe_q   <= m_fe_q;
    end
  end

  assign out_valid_o = ov_q;
  assign grad_o      = grad_q;
  assign frame_end_o = fe_q;

endmodule
`default_nettype wire

// ===== sv/max_neighbor_gradient_3x3_core.sv =====
// Channel   Dir  Handshake        Payload
// pix_i     in   valid / ready    mode (pixel or flush tick), pixel
// grad_o    out  valid / ready    grad_value, frame_end
// cfg       in   cfg_we_i only    cfg_idx_i (0 width, 1 height), cfg_wdata_i
//
// One transaction per cycle is taken in steady state, unless the queue is full or the
// divider is busy. A result passes the line store read, queue, window and output
// register before it is offered. A configuration write holds off input while a
// bit-serial divider re-derives the output row and column from the output index.
// Reset clears counters, window and control; the line store is not cleared.
// Either side may stall independently; the queue and output register absorb it.
`default_nettype none
module max_neighbor_gradient_3x3_core
  import mng_pkg::*;
#(
  parameter int MAX_LINE = DEF_MAX_LINE
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  mng_in_if.sink                     pix_i,
  mng_out_if.source                  grad_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Front to queue
  logic     q_push;
  q_entry_t q_in;
  logic     q_full;

  // Queue to back
  logic     q_valid;
  q_entry_t q_head;
  logic     q_pop;

  // Front: register the frame size, classify each transaction, track input
  // and output positions, read the two previous lines and write them back.
  mng_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .in_mode_i   (pix_i.mode),
    .in_pixel_i  (pix_i.pixel),
    .q_push_o    (q_push),
    .q_entry_o   (q_in),
    .q_full_i    (q_full)
  );

  // Short queue: lets the front keep accepting while the result side stalls
  mng_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_head),
    .pop_i   (q_pop)
  );

  // Back: advance the 3x3 window, form the neighbourhood gradient, hold the
  // result in the output register until the sink takes it.
  mng_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (grad_o.valid),
    .out_ready_i (grad_o.ready),
    .grad_o      (grad_o.grad_value),
    .frame_end_o (grad_o.frame_end)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  import mng_pkg::*;

  localparam int          CLK_HALF      = 6;
  localparam int          RESET_CYCLES  = 11;
  // Generous ceiling: the slowest legal run stays far below this
  localparam int unsigned CYCLE_LIMIT   = 600000;
  // Cycles to let the block settle once nothing more is expected
  localparam int          SETTLE_CYCLES = 16;
  // Length of the long receiver hold-off that backs the block up
  localparam int          HOLD_CYCLES   = 300;
  // Random transactions per idling phase
  localparam int unsigned PHASE_ITEMS   = 370;
  // Pixels sent along the first line at full width; these columns were all
  // filled by the backpressure frame
  localparam int          WIDE_RUN      = 10;
  // Stop printing mismatch detail after this many failures
  localparam int          REPORT_CAP    = 40;

  typedef struct packed {
    logic [PIX_W-1:0] grad_value;
    logic             frame_end;
  } grad_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mng_in_if  pix_if ();
  mng_out_if grad_if ();

  max_neighbor_gradient_3x3_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .pix_i       (pix_if.sink),
    .grad_o      (grad_if.source),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Filter state as the testbench tracks it: two line stores, the 3x3 window,
  // the input position, the raster index of the next result and both sizes.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]        line_above [DEF_MAX_LINE];
  logic [PIX_W-1:0]        line_mid   [DEF_MAX_LINE];
  logic [PIX_W-1:0]        win        [3][3];
  int unsigned             col_cnt;
  int unsigned             row_cnt;
  int unsigned             out_idx;
  logic [CFG_WIDTH_W-1:0]  width_reg;
  logic [CFG_HEIGHT_W-1:0] height_reg;

  // Gradients still owed by the block, oldest first
  grad_result_t grad_q [$];
  grad_result_t grad_head;

  int          errors       = 0;
  int unsigned items_sent   = 0;
  int          src_idle_pct = 30;
  int          snk_idle_pct = 73;
  bit          hold_active  = 1'b0;
  event        hold_off_ev;
  int unsigned cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Sizes in use: width clamped to 3..line length, height at least 3
  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(width_reg);
    if (w < 3) w = 3;
    if (w > DEF_MAX_LINE) w = DEF_MAX_LINE;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = 32'(height_reg);
    if (h < 3) h = 3;
    return h;
  endfunction

  // |max of the eight neighbours - centre| for raster index p; 0 on the border
  // or anywhere outside the frame as it is now sized
  function automatic logic [PIX_W-1:0] neighbourhood_grad(int unsigned p, int unsigned w,
                                                          int unsigned h);
    int unsigned      r;
    int unsigned      c;
    logic [PIX_W-1:0] peak;
    int               i;
    int               j;
    r    = p / w;
    c    = p % w;
    peak = '0;
    if (r == 0 || r >= h - 1 || c == 0 || c >= w - 1) return '0;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1) && win[i][j] > peak) peak = win[i][j];
      end
    end
    return (peak >= win[1][1]) ? peak - win[1][1] : win[1][1] - peak;
  endfunction

  // Advance the tracked state by one accepted transaction and queue the
  // gradient it releases, if any
  function automatic void track_transaction(logic m, logic [PIX_W-1:0] px);
    int unsigned       w;
    int unsigned       h;
    int unsigned       n;
    longint unsigned   total;
    logic [PIX_W-1:0]  up;
    logic [PIX_W-1:0]  mid;
    grad_result_t      res;
    int                i;
    w     = eff_width();
    h     = eff_height();
    total = 64'(w) * 64'(h);
    up    = '0;
    mid   = '0;
    if (m == MODE_PIXEL) begin
      // Drop pixels past the end of the frame until the flush completes
      if (row_cnt >= h) return;
      n = row_cnt * w + col_cnt;
      if (col_cnt < DEF_MAX_LINE) begin
        up                  = line_above[col_cnt];
        mid                 = line_mid[col_cnt];
        line_above[col_cnt] = mid;
        line_mid[col_cnt]   = px;
      end
      for (i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = px;
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      // The first line plus one pixel only primes the window
      if (n >= w + 1) begin
        res.grad_value = neighbourhood_grad(out_idx, w, h);
        res.frame_end  = (out_idx >= total - 1);
        grad_q.push_back(res);
        out_idx++;
      end
    end else begin
      // Drop a flush tick until every pixel of the frame is in
      if (row_cnt < h) return;
      res.grad_value = neighbourhood_grad(out_idx, w, h);
      res.frame_end  = (out_idx >= total - 1);
      grad_q.push_back(res);
      if (res.frame_end) begin
        col_cnt = 0;
        row_cnt = 0;
        out_idx = 0;
      end else begin
        out_idx++;
      end
    end
  endfunction

  // Mostly uniform grey, with the two extremes favoured
  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Width word: mostly small, sometimes below range or wider; the bits above
  // the width field are randomised since the register ignores them
  function automatic logic [CFG_DATA_W-1:0] random_width_word();
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      0:       word[CFG_WIDTH_W-1:0] = CFG_WIDTH_W'($urandom_range(0, 2));
      1:       word[CFG_WIDTH_W-1:0] = CFG_WIDTH_W'($urandom_range(13, 40));
      default: word[CFG_WIDTH_W-1:0] = CFG_WIDTH_W'($urandom_range(3, 12));
    endcase
    return word;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_height_word();
    if ($urandom_range(0, 9) == 0) return CFG_DATA_W'($urandom_range(0, 2));
    return CFG_DATA_W'($urandom_range(3, 8));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: optionally idle, then offer one transaction and hold it until the
  // block takes it. Called in step with the clock; returns as soon as the block
  // has accepted the transaction.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic m, input logic [PIX_W-1:0] px);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    pix_if.valid <= 1'b1;
    pix_if.mode  <= m;
    pix_if.pixel <= px;
    do @(posedge clk); while (!pix_if.ready);
    track_transaction(m, px);
    items_sent++;
  endtask

  // Drop valid, wait for every owed gradient, then let the pipeline settle
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (grad_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; only ever called with the block idle
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) width_reg = value[CFG_WIDTH_W-1:0];
    else height_reg = value[CFG_HEIGHT_W-1:0];
  endtask

  // Feed the rest of the current frame, then flush it out. With noise, slip in
  // flush ticks before the frame is complete, a pixel past its end and a flush
  // after it has drained; the block drops all of those.
  task automatic run_frame(input int noise_pct);
    while (row_cnt < eff_height()) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(MODE_FLUSH, random_pixel());
      send_item(MODE_PIXEL, random_pixel());
    end
    if ($urandom_range(0, 99) < noise_pct) send_item(MODE_PIXEL, random_pixel());
    while (row_cnt >= eff_height()) send_item(MODE_FLUSH, random_pixel());
    if ($urandom_range(0, 99) < noise_pct) send_item(MODE_FLUSH, random_pixel());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Smallest frame, twice: a bright centre in a black field, then a black
  // centre beside a white neighbour. Around them: a flush before any frame is
  // complete, a pixel after the last one, and a flush once the frame is done.
  task automatic test_directed();
    int k;
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    send_item(MODE_FLUSH, '1);
    for (k = 0; k < 9; k++) send_item(MODE_PIXEL, (k == 4) ? 8'hff : 8'h00);
    send_item(MODE_PIXEL, 8'h5a);
    while (row_cnt >= eff_height()) send_item(MODE_FLUSH, 8'h00);
    send_item(MODE_FLUSH, 8'h00);
    for (k = 0; k < 9; k++)
      send_item(MODE_PIXEL, (k == 4) ? 8'h00 : ((k == 8) ? 8'hff : PIX_W'(k)));
    while (row_cnt >= eff_height()) send_item(MODE_FLUSH, 8'hff);
  endtask

  // Hold the receiver off for a long stretch while a whole frame is offered,
  // so the block fills up and stalls its input
  task automatic test_backpressure();
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(12));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(8));
    -> hold_off_ev;
    run_frame(0);
  endtask

  // Well-formed frames of random size and content with a little noise;
  // resize only between frames
  task automatic test_random_frames();
    int unsigned stop_at;
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      wait_idle();
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_WIDTH, random_width_word());
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_HEIGHT, random_height_word());
      run_frame(8);
    end
  endtask

  // Resize in the middle of a frame: widen, narrow below the current column,
  // then cut the height below the current row so the rest drains by flushing.
  // Every column touched here was filled by an earlier complete frame.
  task automatic test_resize_midframe();
    int k;
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(6));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(6));
    for (k = 0; k < 15; k++) send_item(MODE_PIXEL, random_pixel());
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(10));
    for (k = 0; k < 12; k++) send_item(MODE_PIXEL, random_pixel());
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(4));
    for (k = 0; k < 5; k++) send_item(MODE_PIXEL, random_pixel());
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    run_frame(50);
  endtask

  // All-ones width (clamped to the full line): a short run along the first
  // line, then narrow the width so the line wraps and the frame ends small.
  // After that, a frame started at all-ones height and cut short after a few
  // lines.
  task automatic test_large_frames();
    int k;
    wait_idle();
    write_reg(REG_FRAME_WIDTH, '1);
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    for (k = 0; k < WIDE_RUN; k++) send_item(MODE_PIXEL, random_pixel());
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
    run_frame(0);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_FRAME_HEIGHT, '1);
    while (row_cnt < 4) send_item(MODE_PIXEL, random_pixel());
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(6));
    run_frame(0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, forced low while a hold-off runs
  // ---------------------------------------------------------------------------
  initial begin
    grad_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      grad_if.ready <= !hold_active && ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Count out the long hold-off in cycles
  initial forever begin
    @(hold_off_ev);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  // Check every accepted gradient against the oldest one owed
  always @(posedge clk) begin
    if (rst_n && grad_if.valid && grad_if.ready) begin
      if (grad_q.size() == 0) begin
        if (errors < REPORT_CAP)
          $display("%0t: unexpected result, expected none, actual grad_value=%0d frame_end=%0b",
                   $time, grad_if.grad_value, grad_if.frame_end);
        errors++;
      end else begin
        grad_head = grad_q.pop_front();
        if (grad_if.grad_value !== grad_head.grad_value) begin
          if (errors < REPORT_CAP)
            $display("%0t: grad_value mismatch, expected %0d, actual %0d",
                     $time, grad_head.grad_value, grad_if.grad_value);
          errors++;
        end
        if (grad_if.frame_end !== grad_head.frame_end) begin
          if (errors < REPORT_CAP)
            $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                     $time, grad_head.frame_end, grad_if.frame_end);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if it overstays the cycle limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: cycle limit reached with %0d results outstanding", $time, grad_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, then the tests under three idling mixes
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_FRAME_WIDTH;
    cfg_wdata    = '0;
    pix_if.valid = 1'b0;
    pix_if.mode  = MODE_PIXEL;
    pix_if.pixel = '0;
    for (i = 0; i < DEF_MAX_LINE; i++) begin
      line_above[i] = '0;
      line_mid[i]   = '0;
    end
    for (i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
    col_cnt    = 0;
    row_cnt    = 0;
    out_idx    = 0;
    width_reg  = CFG_WIDTH_W'(WIDTH_RESET);
    height_reg = CFG_HEIGHT_W'(HEIGHT_RESET);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles a little, receiver a lot
    src_idle_pct = 30;
    snk_idle_pct = 73;
    test_directed();
    test_backpressure();
    test_random_frames();

    // Swap the roles over
    src_idle_pct = 73;
    snk_idle_pct = 30;
    test_random_frames();
    test_resize_midframe();

    // Full rate on both sides
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_frames();
    test_large_frames();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
